// ----- rtl/rtcq_pkg.sv -----
// shared constants, types and helpers of the rectangle table collision query unit
package rtcq_pkg;

    // table size and coordinate width
    localparam int MAX_ENTRIES = 32;
    localparam int COORD_BITS  = 16;

    // fixed field widths of the stream items
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 5;
    localparam int IN_POS_W = 16;
    localparam int SIZE_W   = 15;
    localparam int HIDX_W   = 5;
    localparam int STAT_W   = 2;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;

    // derived widths
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
    localparam int RR_W   = 2 * SIZE_W;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DSQ_W  = SQ_W + 1;
    localparam int CMP_W  = (DSQ_W > RR_W) ? DSQ_W : RR_W;
    localparam int RES_CAP = 32;
    localparam int RCNT_W = $clog2(RES_CAP + 1);
    localparam int POS_W  = 2 * COORD_BITS;
    localparam int DIM_W  = 2 * SIZE_W;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // request kinds and decoded operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SETPOS = 3'd2;
    localparam logic [OP_W-1:0] OP_RECT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd4;
    localparam logic [OP_W-1:0] OP_POINT  = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SLOT  = 2'd3;

    // decoded request as it waits in the queue
    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic [SLOT_W-1:0]            slot;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [SUM_W-1:0]      qx2;
        logic signed [SUM_W-1:0]      qy2;
        logic [SIZE_W-1:0]            w;
        logic [SIZE_W-1:0]            h;
        logic [RR_W-1:0]              rr;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic                 hit;
        logic [HIDX_W-1:0]    hit_index;
        logic                 last;
        logic [STAT_W-1:0]    status;
    } res_t;

    // sign-extend a 16-bit input coordinate and wrap it to the coordinate width
    function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [IN_POS_W-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(signed'(raw));
        return ext[COORD_BITS-1:0];
    endfunction

    // table index reduced to the result index field
    function automatic logic [HIDX_W-1:0] hidx_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+HIDX_W-1:0] ext;
        ext = (IDX_W + HIDX_W)'(idx);
        return ext[HIDX_W-1:0];
    endfunction

endpackage

// ----- rtl/rtcq_ram.sv -----
// generic single-write, single-read ram with registered read data
module rtcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/rtcq_front.sv -----
// front end: takes requests, decodes the kind and precomputes query bounds
module rtcq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rtcq_pkg::KIND_W-1:0]        kind,
    input  logic [rtcq_pkg::SLOT_W-1:0]        slot,
    input  logic [rtcq_pkg::IN_POS_W-1:0]      pos_x,
    input  logic [rtcq_pkg::IN_POS_W-1:0]      pos_y,
    input  logic [rtcq_pkg::SIZE_W-1:0]        width,
    input  logic [rtcq_pkg::SIZE_W-1:0]        height,
    input  logic [rtcq_pkg::SIZE_W-1:0]        radius,
    output logic                               push,
    input  logic                               push_ready,
    output rtcq_pkg::cmd_t                     cmd
);
    import rtcq_pkg::*;

    logic                   fr_vld_reg;
    logic                   fr_vld_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [IN_POS_W-1:0]    pos_x_reg;
    logic [IN_POS_W-1:0]    pos_y_reg;
    logic [SIZE_W-1:0]      width_reg;
    logic [SIZE_W-1:0]      height_reg;
    logic [SIZE_W-1:0]      radius_reg;
    logic                   accept;
    logic [OP_W-1:0]        op_dec;
    logic signed [SUM_W-1:0] px_ext;
    logic signed [SUM_W-1:0] py_ext;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] h_ext;

    // one request held here until the queue takes it
    assign s_tready = !fr_vld_reg || push_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = fr_vld_reg;

    always_comb
    begin
        fr_vld_next = fr_vld_reg;
        if (accept)
        begin
            fr_vld_next = 1'b1;
        end
        else if (push_ready)
        begin
            fr_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_vld_reg <= 1'b0;
        end
        else
        begin
            fr_vld_reg <= fr_vld_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            slot_reg   <= slot;
            pos_x_reg  <= pos_x;
            pos_y_reg  <= pos_y;
            width_reg  <= width;
            height_reg <= height;
            radius_reg <= radius;
        end
    end

    // kind decode, unused kinds become a no-op
    always_comb
    begin
        unique case (kind_reg) inside
            OP_APPEND, OP_REMOVE, OP_SETPOS, OP_RECT, OP_CIRCLE, OP_POINT:
            begin
                op_dec = kind_reg;
            end
            default:
            begin
                op_dec = OP_NOP;
            end
        endcase
    end

    // coordinates, far rect query corner and squared radius
    always_comb
    begin
        cmd.op   = op_dec;
        cmd.slot = slot_reg;
        cmd.px   = coord_of(pos_x_reg);
        cmd.py   = coord_of(pos_y_reg);
        px_ext   = SUM_W'(cmd.px);
        py_ext   = SUM_W'(cmd.py);
        w_ext    = SUM_W'(width_reg);
        h_ext    = SUM_W'(height_reg);
        cmd.qx2  = px_ext + w_ext;
        cmd.qy2  = py_ext + h_ext;
        cmd.w    = width_reg;
        cmd.h    = height_reg;
        cmd.rr   = RR_W'(radius_reg) * RR_W'(radius_reg);
    end

endmodule

// ----- rtl/rtcq_queue.sv -----
// short fifo of decoded requests between front and back
module rtcq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    output logic            in_ready,
    input  rtcq_pkg::cmd_t  in_cmd,
    output logic            out_vld,
    input  logic            out_pop,
    output rtcq_pkg::cmd_t  out_cmd
);
    import rtcq_pkg::*;

    cmd_t              entries [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign in_ready = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign out_vld  = (cnt_reg != '0);
    assign out_cmd  = entries[rd_ptr_reg];
    assign do_push  = in_vld && in_ready;
    assign do_pop   = out_pop && out_vld;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/rtcq_back.sv -----
// back end: table updates, pipelined entry scan and result output register
module rtcq_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_vld,
    output logic            q_pop,
    input  rtcq_pkg::cmd_t  q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output rtcq_pkg::res_t  m_res
);
    import rtcq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;
    localparam int SC_W = SLOT_W + CNT_W;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic              hold_vld_reg;
    logic              hold_vld_next;
    logic [IDX_W-1:0]  hold_idx_reg;
    logic [IDX_W-1:0]  hold_idx_next;
    logic [RCNT_W-1:0] hit_cnt_reg;
    logic [RCNT_W-1:0] hit_cnt_next;
    logic              out_vld_reg;
    res_t              out_res_reg;
    res_t              out_res_next;
    logic              out_load;
    logic              out_free;

    // query parameters
    logic [OP_W-1:0]              qop_reg;
    logic signed [SUM_W-1:0]      qpx_reg;
    logic signed [SUM_W-1:0]      qpy_reg;
    logic signed [SUM_W-1:0]      qx2_reg;
    logic signed [SUM_W-1:0]      qy2_reg;
    logic [RR_W-1:0]              qrr_reg;
    logic                         qry_load;

    // table memories
    logic                 pos_we;
    logic                 size_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [POS_W-1:0]     pos_rd;
    logic [DIM_W-1:0]     size_rd;
    logic                 issue;
    logic                 issue_tail;
    logic [SC_W-1:0]      slot_ext;

    // scan pipeline
    logic                         p1_vld_reg;
    logic [IDX_W-1:0]             p1_idx_reg;
    logic                         p1_tail_reg;
    logic                         p2_vld_reg;
    logic [IDX_W-1:0]             p2_idx_reg;
    logic                         p2_tail_reg;
    logic signed [SUM_W-1:0]      p2_ex_reg;
    logic signed [SUM_W-1:0]      p2_ey_reg;
    logic signed [SUM_W-1:0]      p2_ex2_reg;
    logic signed [SUM_W-1:0]      p2_ey2_reg;
    logic                         p3_vld_reg;
    logic [IDX_W-1:0]             p3_idx_reg;
    logic                         p3_tail_reg;
    logic                         p3_box_reg;
    logic [COORD_BITS-1:0]        p3_dx_reg;
    logic [COORD_BITS-1:0]        p3_dy_reg;
    logic                         p4_vld_reg;
    logic [IDX_W-1:0]             p4_idx_reg;
    logic                         p4_tail_reg;
    logic                         p4_box_reg;
    logic [SQ_W-1:0]              p4_sqx_reg;
    logic [SQ_W-1:0]              p4_sqy_reg;

    logic signed [COORD_BITS-1:0] e_x;
    logic signed [COORD_BITS-1:0] e_y;
    logic signed [SUM_W-1:0]      e_xs;
    logic signed [SUM_W-1:0]      e_ys;
    logic signed [SUM_W-1:0]      e_ws;
    logic signed [SUM_W-1:0]      e_hs;
    logic                         rect_hit;
    logic                         point_hit;
    logic signed [SUM_W-1:0]      dx_diff;
    logic signed [SUM_W-1:0]      dy_diff;
    logic [COORD_BITS-1:0]        dx_mag;
    logic [COORD_BITS-1:0]        dy_mag;
    logic [DSQ_W-1:0]             dist_sq;
    logic                         circ_hit;
    logic                         p4_hit;
    logic                         take_hit;

    assign out_free = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_res    = out_res_reg;
    assign slot_ext = SC_W'(q_cmd.slot);
    assign issue_tail = (CNT_W'(rd_idx_reg) == (cnt_reg - CNT_W'(1)));

    rtcq_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_ENTRIES)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_we),
        .wr_addr (wr_addr),
        .wr_data ({q_cmd.py, q_cmd.px}),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg),
        .rd_data (pos_rd)
    );

    rtcq_ram #(
        .WIDTH (DIM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (size_we),
        .wr_addr (wr_addr),
        .wr_data ({q_cmd.h, q_cmd.w}),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg),
        .rd_data (size_rd)
    );

    // stage 1: far corner of the entry read from the table
    always_comb
    begin
        e_x  = pos_rd[COORD_BITS-1:0];
        e_y  = pos_rd[POS_W-1:COORD_BITS];
        e_xs = SUM_W'(e_x);
        e_ys = SUM_W'(e_y);
        e_ws = SUM_W'(size_rd[SIZE_W-1:0]);
        e_hs = SUM_W'(size_rd[DIM_W-1:SIZE_W]);
    end

    // stage 2: box tests and clamped distance per axis
    always_comb
    begin
        rect_hit  = !(p2_ex_reg > qx2_reg) && !(p2_ex2_reg < qpx_reg) &&
                    !(p2_ey_reg > qy2_reg) && !(p2_ey2_reg < qpy_reg);
        point_hit = (qpx_reg <= p2_ex2_reg) && (qpx_reg >= p2_ex_reg) &&
                    (qpy_reg <= p2_ey2_reg) && (qpy_reg >= p2_ey_reg);
        if (qpx_reg < p2_ex_reg)
        begin
            dx_diff = p2_ex_reg - qpx_reg;
        end
        else if (qpx_reg > p2_ex2_reg)
        begin
            dx_diff = qpx_reg - p2_ex2_reg;
        end
        else
        begin
            dx_diff = '0;
        end
        if (qpy_reg < p2_ey_reg)
        begin
            dy_diff = p2_ey_reg - qpy_reg;
        end
        else if (qpy_reg > p2_ey2_reg)
        begin
            dy_diff = qpy_reg - p2_ey2_reg;
        end
        else
        begin
            dy_diff = '0;
        end
        dx_mag = dx_diff[COORD_BITS-1:0];
        dy_mag = dy_diff[COORD_BITS-1:0];
    end

    // stage 4: distance compare and hit select
    always_comb
    begin
        dist_sq  = DSQ_W'(p4_sqx_reg) + DSQ_W'(p4_sqy_reg);
        circ_hit = CMP_W'(dist_sq) < CMP_W'(qrr_reg);
        p4_hit   = (qop_reg == OP_CIRCLE) ? circ_hit : p4_box_reg;
        take_hit = p4_vld_reg && p4_hit && (hit_cnt_reg < RCNT_W'(RES_CAP)) && out_free;
    end

    // control: table commands, scan sequencing and result emission
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        hold_vld_next = hold_vld_reg;
        hold_idx_next = hold_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        q_pop         = 1'b0;
        qry_load      = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        out_res_next  = '{hit: 1'b0, hit_index: '0, last: 1'b1, status: STAT_OK};
        pos_we        = 1'b0;
        size_we       = 1'b0;
        wr_addr       = slot_ext[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_vld && out_free)
                begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    unique case (q_cmd.op) inside
                        OP_APPEND:
                        begin
                            if (cnt_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                out_res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                pos_we   = 1'b1;
                                size_we  = 1'b1;
                                wr_addr  = cnt_reg[IDX_W-1:0];
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        OP_SETPOS:
                        begin
                            if (slot_ext >= SC_W'(cnt_reg))
                            begin
                                out_res_next.status = STAT_SLOT;
                            end
                            else
                            begin
                                pos_we = 1'b1;
                            end
                        end
                        OP_RECT, OP_CIRCLE, OP_POINT:
                        begin
                            // an empty table answers at once with no hit
                            if (cnt_reg != '0)
                            begin
                                out_load      = 1'b0;
                                qry_load      = 1'b1;
                                rd_idx_next   = '0;
                                hold_vld_next = 1'b0;
                                hit_cnt_next  = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    issue = 1'b1;
                    if (issue_tail)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free && p4_vld_reg && p4_tail_reg)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // the held hit, if any, closes the query
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (hold_vld_reg)
                    begin
                        out_res_next.hit       = 1'b1;
                        out_res_next.hit_index = hidx_of(hold_idx_reg);
                    end
                    hold_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new hit pushes the previously held one out as a non-final result
        if (take_hit)
        begin
            hit_cnt_next  = hit_cnt_reg + RCNT_W'(1);
            hold_vld_next = 1'b1;
            hold_idx_next = p4_idx_reg;
            if (hold_vld_reg)
            begin
                out_load               = 1'b1;
                out_res_next.hit       = 1'b1;
                out_res_next.hit_index = hidx_of(hold_idx_reg);
                out_res_next.last      = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            hold_vld_reg <= 1'b0;
            hit_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            p4_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            hold_vld_reg <= hold_vld_next;
            hit_cnt_reg  <= hit_cnt_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (out_free)
            begin
                p1_vld_reg <= issue;
                p2_vld_reg <= p1_vld_reg;
                p3_vld_reg <= p2_vld_reg;
                p4_vld_reg <= p3_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_idx_reg <= hold_idx_next;
        if (out_load)
        begin
            out_res_reg <= out_res_next;
        end
        if (qry_load)
        begin
            qop_reg <= q_cmd.op;
            qpx_reg <= SUM_W'(q_cmd.px);
            qpy_reg <= SUM_W'(q_cmd.py);
            qx2_reg <= q_cmd.qx2;
            qy2_reg <= q_cmd.qy2;
            qrr_reg <= q_cmd.rr;
        end
        if (out_free)
        begin
            p1_idx_reg  <= rd_idx_reg;
            p1_tail_reg <= issue_tail;
            p2_idx_reg  <= p1_idx_reg;
            p2_tail_reg <= p1_tail_reg;
            p2_ex_reg   <= e_xs;
            p2_ey_reg   <= e_ys;
            p2_ex2_reg  <= e_xs + e_ws;
            p2_ey2_reg  <= e_ys + e_hs;
            p3_idx_reg  <= p2_idx_reg;
            p3_tail_reg <= p2_tail_reg;
            p3_box_reg  <= (qop_reg == OP_RECT) ? rect_hit : point_hit;
            p3_dx_reg   <= dx_mag;
            p3_dy_reg   <= dy_mag;
            p4_idx_reg  <= p3_idx_reg;
            p4_tail_reg <= p3_tail_reg;
            p4_box_reg  <= p3_box_reg;
            p4_sqx_reg  <= SQ_W'(p3_dx_reg) * SQ_W'(p3_dx_reg);
            p4_sqy_reg  <= SQ_W'(p3_dy_reg) * SQ_W'(p3_dy_reg);
        end
    end

    // the output register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && out_vld_reg && !m_tready))
        else $error("result register overwritten while stalled");

    // scan pipeline only carries entries during a query
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p4_vld_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("scan stage valid outside a query");

    // no held hit survives the end of a query
    a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_vld_reg)
        else $error("held hit left over in idle");

    // table fill stays in range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // the final flush always follows the tail entry leaving the pipeline
    a_flush_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && out_free && p4_vld_reg && p4_tail_reg)
        |=> (state_reg == S_FLUSH && !p4_vld_reg))
        else $error("query end not followed by flush");

endmodule

// ----- rtl/rect_table_collision_query_unit.sv -----
// top level of the rectangle table collision query unit
//
//  channel | dir | signals                          | contents
//  --------+-----+----------------------------------+---------------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata s_tuser| one request: table command or query
//  m_*     | out | m_tvalid m_tready m_tdata m_tlast| one result, m_tlast ends a request
//
//  table commands leave the back end one per cycle unless a stalled m_tready holds them
//  a query holds the back end through decode, a read of both table rams per entry at
//  one shared address, the scan pipeline stages, then the final result
//  reset clears the entry count and control state; table contents are undefined until written
//  a stalled m_tready freezes the scan pipeline; up to three requests queue on the input
module rect_table_collision_query_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot[4:0] pos_x[20:5] pos_y[36:21] width[51:37] height[66:52] radius[81:67]
    input  logic [rtcq_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind[2:0]
    input  logic [rtcq_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit[0] hit_index[5:1] status[7:6]
    output logic [rtcq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import rtcq_pkg::*;

    logic  push;
    logic  push_ready;
    cmd_t  front_cmd;
    logic  q_vld;
    logic  q_pop;
    cmd_t  q_cmd;
    res_t  res;

    rtcq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .kind       (s_tuser),
        .slot       (s_tdata[4:0]),
        .pos_x      (s_tdata[20:5]),
        .pos_y      (s_tdata[36:21]),
        .width      (s_tdata[51:37]),
        .height     (s_tdata[66:52]),
        .radius     (s_tdata[81:67]),
        .push       (push),
        .push_ready (push_ready),
        .cmd        (front_cmd)
    );

    rtcq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (push),
        .in_ready (push_ready),
        .in_cmd   (front_cmd),
        .out_vld  (q_vld),
        .out_pop  (q_pop),
        .out_cmd  (q_cmd)
    );

    rtcq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_vld    (q_vld),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    // result packing
    assign m_tdata = {res.status, res.hit_index, res.hit};
    assign m_tlast = res.last;

endmodule

// ----- bench/rtcq_overlap_checker.sv -----
// result checker for the rectangle table collision query unit: predicts and compares results
`timescale 1ns / 1ps

module rtcq_overlap_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rtcq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [rtcq_pkg::KIND_W-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rtcq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    output int                               mismatch_count,
    output int                               awaited_count
);
    import rtcq_pkg::*;

    // shadow copy of the rectangle table
    logic signed [COORD_BITS-1:0] tab_x [MAX_ENTRIES];
    logic signed [COORD_BITS-1:0] tab_y [MAX_ENTRIES];
    logic [SIZE_W-1:0]            tab_w [MAX_ENTRIES];
    logic [SIZE_W-1:0]            tab_h [MAX_ENTRIES];
    int                           tab_count = 0;

    // results still owed by the block, oldest first
    res_t awaited_results [$];
    int   result_number   = 0;

    initial
    begin
        mismatch_count = 0;
        awaited_count  = 0;
    end

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch: %s", what);
    endtask

    // sign-extend a 16-bit request coordinate, then wrap it to the table coordinate width
    function automatic longint wrap_coord(input logic [IN_POS_W-1:0] raw);
        longint                       ext;
        logic signed [COORD_BITS-1:0] wrapped;
        ext     = longint'($signed(raw));
        wrapped = ext[COORD_BITS-1:0];
        return longint'(wrapped);
    endfunction

    // overlap test of one stored entry against the query
    function automatic bit entry_is_hit(input int idx, input logic [KIND_W-1:0] kind,
                                        input longint px, input longint py,
                                        input longint qw, input longint qh,
                                        input longint rad);
        longint ex;
        longint ey;
        longint ex2;
        longint ey2;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        ex  = longint'(tab_x[idx]);
        ey  = longint'(tab_y[idx]);
        ex2 = ex + longint'(tab_w[idx]);
        ey2 = ey + longint'(tab_h[idx]);
        if (kind == OP_RECT)
            return !(ex > px + qw || ex2 < px || ey > py + qh || ey2 < py);
        if (kind == OP_CIRCLE)
        begin
            cx = (px < ex) ? ex : ((px > ex2) ? ex2 : px);
            cy = (py < ey) ? ey : ((py > ey2) ? ey2 : py);
            dx = px - cx;
            dy = py - cy;
            return (dx * dx + dy * dy) < (rad * rad);
        end
        return px >= ex && px <= ex2 && py >= ey && py <= ey2;
    endfunction

    // queue one owed result
    task automatic owe_result(input logic hit, input logic [HIDX_W-1:0] idx,
                              input logic last, input logic [STAT_W-1:0] status);
        res_t r;
        r.hit       = hit;
        r.hit_index = idx;
        r.last      = last;
        r.status    = status;
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // apply one accepted request to the shadow table and work out its results
    task automatic predict_request(input logic [KIND_W-1:0] kind,
                                   input logic [IN_TDATA_W-1:0] data);
        logic [SLOT_W-1:0] slot;
        longint            px;
        longint            py;
        longint            qw;
        longint            qh;
        longint            rad;
        int                hit_list [RES_CAP];
        int                n;
        slot = data[4:0];
        px   = wrap_coord(data[20:5]);
        py   = wrap_coord(data[36:21]);
        qw   = longint'(data[51:37]);
        qh   = longint'(data[66:52]);
        rad  = longint'(data[81:67]);
        n    = 0;
        case (kind)
            OP_APPEND:
            begin
                if (tab_count >= MAX_ENTRIES)
                    owe_result(1'b0, '0, 1'b1, STAT_FULL);
                else
                begin
                    tab_x[tab_count] = px[COORD_BITS-1:0];
                    tab_y[tab_count] = py[COORD_BITS-1:0];
                    tab_w[tab_count] = data[51:37];
                    tab_h[tab_count] = data[66:52];
                    tab_count++;
                    owe_result(1'b0, '0, 1'b1, STAT_OK);
                end
            end
            OP_REMOVE:
            begin
                if (tab_count == 0)
                    owe_result(1'b0, '0, 1'b1, STAT_EMPTY);
                else
                begin
                    tab_count--;
                    owe_result(1'b0, '0, 1'b1, STAT_OK);
                end
            end
            OP_SETPOS:
            begin
                if (int'(slot) >= tab_count)
                    owe_result(1'b0, '0, 1'b1, STAT_SLOT);
                else
                begin
                    tab_x[slot] = px[COORD_BITS-1:0];
                    tab_y[slot] = py[COORD_BITS-1:0];
                    owe_result(1'b0, '0, 1'b1, STAT_OK);
                end
            end
            OP_RECT, OP_CIRCLE, OP_POINT:
            begin
                // scan in index order, keeping at most one result per hit up to the cap
                for (int i = 0; i < tab_count && n < RES_CAP; i++)
                begin
                    if (entry_is_hit(i, kind, px, py, qw, qh, rad))
                    begin
                        hit_list[n] = i;
                        n++;
                    end
                end
                if (n == 0)
                    owe_result(1'b0, '0, 1'b1, STAT_OK);
                for (int j = 0; j < n; j++)
                    owe_result(1'b1, HIDX_W'(hit_list[j]), j == n - 1, STAT_OK);
            end
            default:
                owe_result(1'b0, '0, 1'b1, STAT_OK);
        endcase
    endtask

    // watch both channels; results first, since a request never answers in its own cycle
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            tab_count = 0;
            awaited_results.delete();
            awaited_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.hit       = m_tdata[0];
                got.hit_index = m_tdata[5:1];
                got.last      = m_tlast;
                got.status    = m_tdata[7:6];
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none owed: %p",
                                              result_number, got));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "result %0d hit %b/%b index %0d/%0d last %b/%b status %0d/%0d",
                            result_number, got.hit, want.hit, got.hit_index, want.hit_index,
                            got.last, want.last, got.status, want.status));
                end
                result_number++;
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            awaited_count = awaited_results.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// testbench top of the rectangle table collision query unit: stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import rtcq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
    localparam int                IDLE_LIMIT = 4000;
    localparam int                ITEM_GOAL  = 380;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatch_count;
    int awaited_count;
    int stored     = 0;
    int sent_items = 0;
    bit calm       = 1'b0;

    rect_table_collision_query_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rtcq_overlap_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // result side back-pressure, off during the calm stretch
    always @(negedge clk)
    begin
        m_tready = calm || ($urandom_range(99) >= 11);
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // send one request, called and returning at a falling edge
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [SIZE_W-1:0] rad);
        calm = (sent_items >= 150 && sent_items < 240);
        while (!calm && $urandom_range(99) < 11)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid       = 1'b1;
        s_tuser        = kind;
        s_tdata        = '0;
        s_tdata[81:0]  = {rad, h, w, y, x, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // track the table fill to shape later traffic
        if (kind == OP_APPEND && stored < MAX_ENTRIES)
            stored++;
        if (kind == OP_REMOVE && stored > 0)
            stored--;
        sent_items++;
        @(negedge clk);
    endtask

    // hold the sender until every owed result is back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
    endtask

    // coordinates mostly clustered so queries hit, sometimes anywhere
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(99) < 85)
            return 16'($urandom_range(400)) - 16'd200;
        return 16'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return '1;
        if (roll < 6)
            return '0;
        if (roll < 84)
            return SIZE_W'($urandom_range(120));
        return SIZE_W'($urandom_range(32767));
    endfunction

    task automatic send_append();
        send_req(OP_APPEND, 5'($urandom), pick_coord(), pick_coord(), pick_size(), pick_size(),
                 pick_size());
    endtask

    task automatic send_remove();
        send_req(OP_REMOVE, 5'($urandom), 16'($urandom), 16'($urandom), pick_size(),
                 pick_size(), pick_size());
    endtask

    // slot mostly inside the table, sometimes anywhere
    task automatic send_move();
        logic [SLOT_W-1:0] slot;
        if (stored > 0 && $urandom_range(3) != 0)
            slot = SLOT_W'($urandom_range(stored - 1));
        else
            slot = SLOT_W'($urandom_range(31));
        send_req(OP_SETPOS, slot, pick_coord(), pick_coord(), pick_size(), pick_size(),
                 pick_size());
    endtask

    task automatic send_query();
        logic [KIND_W-1:0] kind;
        case ($urandom_range(2))
            0: kind = OP_RECT;
            1: kind = OP_CIRCLE;
            default: kind = OP_POINT;
        endcase
        send_req(kind, 5'($urandom), pick_coord(), pick_coord(), pick_size(), pick_size(),
                 pick_size());
    endtask

    // main stimulus
    initial
    begin
        int roll;
        int phase;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table: query, remove and move all have nothing to act on
        send_req(OP_RECT,    5'd0,  16'd0,    16'd0,    15'd10,    15'd10,    15'd0);
        send_req(OP_REMOVE,  5'd0,  16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        send_req(OP_SETPOS,  5'd0,  16'd5,    16'd5,    15'd0,     15'd0,     15'd0);
        // unused kinds
        send_req(OP_NOP,     5'd0,  16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        send_req(KIND_SPARE, 5'd31, 16'hffff, 16'hffff, 15'h7fff,  15'h7fff,  15'h7fff);
        // entries at the coordinate and size extremes
        send_req(OP_APPEND,  5'd0,  16'h8000, 16'h8000, 15'h7fff,  15'h7fff,  15'd0);
        send_req(OP_APPEND,  5'd0,  16'h7fff, 16'h7fff, 15'd0,     15'd0,     15'd0);
        send_req(OP_APPEND,  5'd0,  16'd0,    16'd0,    15'd10,    15'd10,    15'd0);
        // point containment, inclusive edges
        send_req(OP_POINT,   5'd0,  16'h7fff, 16'h7fff, 15'd0,     15'd0,     15'd0);
        send_req(OP_POINT,   5'd0,  16'hffff, 16'hffff, 15'd0,     15'd0,     15'd0);
        send_req(OP_POINT,   5'd0,  16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        // rect overlap touching edges, then just missing
        send_req(OP_RECT,    5'd0,  -16'sd10, -16'sd10, 15'd10,    15'd10,    15'd0);
        send_req(OP_RECT,    5'd0,  16'd11,   16'd0,    15'd5,     15'd5,     15'd0);
        // circle at exactly the radius misses, one more hits
        send_req(OP_CIRCLE,  5'd0,  16'd13,   16'd14,   15'd0,     15'd0,     15'd5);
        send_req(OP_CIRCLE,  5'd0,  16'd13,   16'd14,   15'd0,     15'd0,     15'd6);
        send_req(OP_CIRCLE,  5'd0,  16'h8000, 16'h7fff, 15'd0,     15'd0,     15'h7fff);
        send_req(OP_CIRCLE,  5'd0,  16'd5,    16'd5,    15'd0,     15'd0,     15'h7fff);
        send_req(OP_CIRCLE,  5'd0,  -16'sd5,  -16'sd5,  15'd0,     15'd0,     15'd0);
        // moves inside and outside the table
        send_req(OP_SETPOS,  5'd2,  16'd100,  -16'sd100, 15'd0,    15'd0,     15'd0);
        send_req(OP_SETPOS,  5'd3,  16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        send_req(OP_SETPOS,  5'd31, 16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        send_req(OP_RECT,    5'd0,  16'h8000, 16'h8000, 15'h7fff,  15'h7fff,  15'd0);
        send_req(OP_REMOVE,  5'd0,  16'd0,    16'd0,    15'd0,     15'd0,     15'd0);
        send_req(OP_POINT,   5'd0,  16'd100,  -16'sd100, 15'd0,    15'd0,     15'd0);
        wait_drained();

        // random phases: fill to full, drain to empty, mixed traffic
        phase = 0;
        while (sent_items < ITEM_GOAL)
        begin
            if (phase == 0 || phase % 6 == 3)
            begin
                while (stored < MAX_ENTRIES)
                begin
                    send_append();
                    if ($urandom_range(3) == 0)
                        send_query();
                end
                send_append();
                send_append();
            end
            else if (phase == 2 || phase % 6 == 5)
            begin
                while (stored > 0)
                begin
                    send_remove();
                    if ($urandom_range(3) == 0)
                        send_query();
                end
                send_remove();
                send_query();
            end
            else
            begin
                for (int k = 0; k < 25; k++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 18)
                        send_append();
                    else if (roll < 28)
                        send_remove();
                    else if (roll < 40)
                        send_move();
                    else if (roll < 94)
                        send_query();
                    else
                        send_req($urandom_range(1) ? OP_NOP : KIND_SPARE, 5'($urandom),
                                 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                                 15'($urandom));
                end
            end
            if (phase == 1 || $urandom_range(3) == 0)
                wait_drained();
            phase++;
        end

        // let the last results come back, then give the block time to show strays
        wait_drained();
        repeat (60) @(negedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rtcq_pkg.sv
rtl/rtcq_ram.sv
rtl/rtcq_front.sv
rtl/rtcq_queue.sv
rtl/rtcq_back.sv
rtl/rect_table_collision_query_unit.sv
bench/rtcq_overlap_checker.sv
bench/tb.sv
